// ===== rtl/core/mmcd_pkg.sv =====
`default_nettype none

package mmcd_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_LEVELS = 12;
   localparam int HEIGHT_CAP = 4096;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(HEIGHT_CAP);
   localparam int ADDR_W = COL_W;
   localparam int OFF_W  = COL_W + 1;
   localparam int WID_W  = COL_W + 1;
   localparam int HGT_W  = ROW_W + 1;
   localparam int LIDX_W = $clog2(MAX_LEVELS);
   localparam int CFG_W  = 13;
   localparam int LEV_W  = 4;
   localparam int CSR_IDX_W = 2;

   // floor(s / 3) == (s * RECIP_3) >> RECIP_SH for s up to 1020
   localparam int RECIP_3  = 683;
   localparam int RECIP_SH = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIP_LEVELS   = 2'd2;

   typedef struct packed {
      logic [7:0] chan_0;
      logic [7:0] chan_1;
      logic [7:0] chan_2;
      logic [7:0] chan_3;
      logic       covered;
   } req_type;

   typedef struct packed {
      logic [3:0]  level;
      logic [10:0] out_x;
      logic [10:0] out_y;
      logic [7:0]  out_chan_0;
      logic [7:0]  out_chan_1;
      logic [7:0]  out_chan_2;
      logic [7:0]  out_chan_3;
      logic        out_covered;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [3:0][7:0] ch;
      logic            cov;
   } pix_type;

   typedef struct packed {
      logic [3:0][8:0] sum;
      logic [1:0]      cnt;
   } pair_type;

endpackage

`default_nettype wire

// ===== rtl/core/mmcd_quad_avg.sv =====
`default_nettype none

module mmcd_quad_avg
   import mmcd_pkg::*;
(
   input  pair_type top_pair,
   input  pair_type bot_pair,
   output pix_type  quad_pix
);

   logic [2:0]  cnt_w;
   logic [9:0]  sum_w  [4];
   logic [19:0] prod_w [4];
   logic [9:0]  quo_w  [4];

   always_comb begin
      cnt_w = 3'({1'b0, top_pair.cnt}) + 3'({1'b0, bot_pair.cnt});
      for (int k = 0; k < 4; k++) begin
         sum_w[k]  = 10'(top_pair.sum[k]) + 10'(bot_pair.sum[k]);
         prod_w[k] = 20'(sum_w[k]) * 20'(RECIP_3);
         case (cnt_w)
            3'd1: quo_w[k] = sum_w[k];
            3'd2: quo_w[k] = sum_w[k] >> 1;
            3'd3: quo_w[k] = 10'(prod_w[k] >> RECIP_SH);
            3'd4: quo_w[k] = sum_w[k] >> 2;
            default: quo_w[k] = '0;
         endcase
         quad_pix.ch[k] = quo_w[k][7:0];
      end
      quad_pix.cov = (cnt_w != 3'd0);
   end

endmodule

`default_nettype wire

// ===== rtl/core/masked_mip_chain_downsample.sv =====
// Masked 2x2 mip chain builder.
// Feed base-level pixels in raster order on the req_ channel (valid/stall);
// each accepted beat may cause up to one result per mip level on the rsp_
// channel, lowest level first, with last set on the final one of that beat.
// A beat that causes nothing produces no rsp beat at all.
// Program image_width, image_height and mip_levels on the csr_ port while the
// block is idle; any write to one of them restarts every level at its origin.
// Each beat takes one level step when it closes no quad, plus a step and a
// merge per level it reaches (one line-store read, one averaging step).
// The single line store port and the per-level walk keep req_stall high until
// idle; the first result is loaded in the step after the first merge.
// Results sit in an output register; while rsp_stall is high the register
// holds and the level walk waits before pushing the next result.
// Reset (synchronous) clears the position counters and restores the
// register defaults of 256 x 256 with one level. The line store is not
// cleared: each entry is written on an even row before the odd row reads it.
`default_nettype none

module masked_mip_chain_downsample
   import mmcd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STEP  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff;

   logic [CFG_W-1:0] wcfg_ff, hcfg_ff;
   logic [LEV_W-1:0] lcfg_ff;

   logic [COL_W-1:0] col_ff  [MAX_LEVELS];
   logic [ROW_W-1:0] row_ff  [MAX_LEVELS];
   pix_type          hold_ff [MAX_LEVELS];

   pix_type           p_ff;
   logic [LIDX_W-1:0] lvl_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [WID_W-1:0]  w_ff;
   logic [HGT_W-1:0]  h_ff;
   logic [LEV_W-1:0]  lev_ff;
   logic [COL_W-1:0]  x_ff;
   logic [ROW_W-1:0]  y_ff;
   pair_type          pr_ff;
   pair_type          rd_data_ff;

   logic              pend_ff;
   logic [LEV_W-1:0]  pend_lvl_ff;
   logic [10:0]       pend_x_ff, pend_y_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [2*MAX_WIDTH/MAX_WIDTH*19-1:0] store_mem [MAX_WIDTH];

   logic             csr_we, csr_hit;
   logic [WID_W-1:0] eff_w;
   logic [HGT_W-1:0] eff_h;
   logic [LEV_W-1:0] eff_lev;
   logic             req_take;
   logic [COL_W-1:0] cur_x;
   logic [ROW_W-1:0] cur_y;
   logic             act, x_last, y_last, idx_ok, made, go, rsp_load;
   logic [OFF_W-1:0] idx;
   logic             mem_we, mem_re;
   pair_type         pair_w;
   pix_type          req_pix, avg_pix;
   rsp_type          rsp_in;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;
   // only a write to a listed register restarts the frame
   assign csr_hit   = csr_we &
                      (csr_index inside {CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_MIP_LEVELS});
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (wcfg_ff == '0)
         eff_w = WID_W'(1);
      else if (int'(wcfg_ff) > MAX_WIDTH)
         eff_w = WID_W'(MAX_WIDTH);
      else
         eff_w = WID_W'(wcfg_ff);
      if (hcfg_ff == '0)
         eff_h = HGT_W'(1);
      else if (int'(hcfg_ff) > HEIGHT_CAP)
         eff_h = HGT_W'(HEIGHT_CAP);
      else
         eff_h = HGT_W'(hcfg_ff);
      if (lcfg_ff == '0)
         eff_lev = LEV_W'(1);
      else if (int'(lcfg_ff) > MAX_LEVELS)
         eff_lev = LEV_W'(MAX_LEVELS);
      else
         eff_lev = lcfg_ff;
   end

   assign req_pix.ch[0] = req_data.chan_0;
   assign req_pix.ch[1] = req_data.chan_1;
   assign req_pix.ch[2] = req_data.chan_2;
   assign req_pix.ch[3] = req_data.chan_3;
   assign req_pix.cov   = req_data.covered;

   // current level step
   always_comb begin
      cur_x  = col_ff[lvl_ff];
      cur_y  = row_ff[lvl_ff];
      act    = (5'(lvl_ff) + 5'd1) < 5'(lev_ff);
      x_last = (WID_W'(cur_x) + WID_W'(1)) >= w_ff;
      y_last = (HGT_W'(cur_y) + HGT_W'(1)) >= h_ff;
      idx    = off_ff + OFF_W'(cur_x >> 1);
      idx_ok = int'(idx) < MAX_WIDTH;
      made   = act & cur_x[0] & cur_y[0] & idx_ok;
      go     = (state_ff == ST_STEP) & (~pend_ff | ~rsp_valid_ff | ~rsp_stall);
      for (int k = 0; k < 4; k++)
         pair_w.sum[k] = 9'(hold_ff[lvl_ff].ch[k]) + 9'(p_ff.ch[k]);
      pair_w.cnt = 2'(hold_ff[lvl_ff].cov) + 2'(p_ff.cov);
      mem_we   = go & act & cur_x[0] & ~cur_y[0] & idx_ok;
      mem_re   = go & made;
      rsp_load = go & pend_ff;
   end

   always_comb begin
      rsp_in.level       = pend_lvl_ff;
      rsp_in.out_x       = pend_x_ff;
      rsp_in.out_y       = pend_y_ff;
      rsp_in.out_chan_0  = p_ff.ch[0];
      rsp_in.out_chan_1  = p_ff.ch[1];
      rsp_in.out_chan_2  = p_ff.ch[2];
      rsp_in.out_chan_3  = p_ff.ch[3];
      rsp_in.out_covered = p_ff.cov;
      rsp_in.last        = ~made;
   end

   mmcd_quad_avg u_avg (
      .top_pair (rd_data_ff),
      .bot_pair (pr_ff),
      .quad_pix (avg_pix)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         wcfg_ff  <= CFG_W'(256);
         hcfg_ff  <= CFG_W'(256);
         lcfg_ff  <= LEV_W'(1);
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  wcfg_ff <= csr_data;
               CSR_IMAGE_HEIGHT: hcfg_ff <= csr_data;
               CSR_MIP_LEVELS:   lcfg_ff <= csr_data[LEV_W-1:0];
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               pend_ff <= 1'b0;
               if (req_take)
                  state_ff <= ST_STEP;
            end
            ST_STEP: begin
               if (go) begin
                  pend_ff  <= 1'b0;
                  state_ff <= made ? ST_MERGE : ST_IDLE;
               end
            end
            ST_MERGE: begin
               pend_ff  <= 1'b1;
               state_ff <= ST_STEP;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // per-level position counters; a write to a listed register restarts the frame
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (go && act) begin
         if (x_last) begin
            col_ff[lvl_ff] <= '0;
            row_ff[lvl_ff] <= y_last ? '0 : cur_y + ROW_W'(1);
         end else begin
            col_ff[lvl_ff] <= cur_x + COL_W'(1);
         end
      end
   end

   // walk payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_take) begin
         p_ff   <= req_pix;
         lvl_ff <= '0;
         off_ff <= '0;
         w_ff   <= eff_w;
         h_ff   <= eff_h;
         lev_ff <= eff_lev;
      end
      if (go && act) begin
         if (!cur_x[0] && !x_last)
            hold_ff[lvl_ff] <= p_ff;
         x_ff  <= cur_x;
         y_ff  <= cur_y;
         pr_ff <= pair_w;
      end
      if (state_ff == ST_MERGE) begin
         p_ff        <= avg_pix;
         pend_lvl_ff <= LEV_W'(lvl_ff) + LEV_W'(1);
         pend_x_ff   <= 11'(x_ff >> 1);
         pend_y_ff   <= 11'(y_ff >> 1);
         lvl_ff      <= lvl_ff + LIDX_W'(1);
         off_ff      <= off_ff + OFF_W'(w_ff >> 1);
         w_ff        <= w_ff >> 1;
         h_ff        <= h_ff >> 1;
      end
   end

   // line store of horizontal pair sums, one region per level
   always_ff @(posedge clock) begin
      if (mem_we)
         store_mem[idx[ADDR_W-1:0]] <= pair_w;
      if (mem_re)
         rd_data_ff <= store_mem[idx[ADDR_W-1:0]];
   end

   // output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (rsp_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load)
         rsp_data_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_merge_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ($past(state_ff) == ST_STEP))
      else $error("merge entered without a level step");

   a_rsp_from_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_STEP && $past(pend_ff)))
      else $error("result raised without a pending pixel");

   a_merge_sets_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |=> (pend_ff && state_ff == ST_STEP))
      else $error("merge did not leave a pending pixel");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (5'(lvl_ff) < 5'(lev_ff)))
      else $error("level walk beyond configured levels");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
